FILE: sv/gri_pkg.sv
// Package for the gyro rate integrator: constants, types, command/status structs
package gri_pkg;

    localparam int ACC_WIDTH = 56;
    localparam int CNT_WIDTH = 32;
    localparam int GAIN_WIDTH = 24;
    localparam int PROD_WIDTH = 40;
    localparam int AMT_WIDTH = 40;
    localparam int DIV_STEPS = ACC_WIDTH;
    localparam int DSTEP_WIDTH = $clog2(DIV_STEPS + 1);

    // Input word: x, y, z, status, tick (tlast carries round_end)
    localparam int IN_WIDTH = 88;
    // Output word: angles, offsets, status, count (tuser carries phase)
    localparam int OUT_WIDTH = 3 * ACC_WIDTH + 3 * AMT_WIDTH + 8 + CNT_WIDTH;
    localparam int OUT_BYTES = (OUT_WIDTH + 7) / 8;
    localparam int OUT_TDATA = OUT_BYTES * 8;

    localparam logic [2:0] REG_RATE_GAIN    = 3'd0;
    localparam logic [2:0] REG_CALIB_TARGET = 3'd1;
    localparam logic [2:0] REG_DRIFT_X      = 3'd2;
    localparam logic [2:0] REG_DRIFT_Y      = 3'd3;
    localparam logic [2:0] REG_DRIFT_Z      = 3'd4;
    localparam logic [2:0] REG_DRIFT_AMT    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_DRIFT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // latch input word, compute products
        logic accum;      // add products into the active accumulators
        logic div_start;  // start mean division for all axes
        logic div_step;   // one restoring-division step
        logic div_done;   // write means, switch phase
        logic drift_start;
        logic drift_step;
        logic drift_apply;
    } t_cmd;

    typedef struct packed {
        logic round_end;
        logic calib_done;  // count, including the current sample, reached target
        logic phase;
        logic div_last;
        logic drift_last;
    } t_sts;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [ACC_WIDTH-1:0] b
    );
        logic signed [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            sat_add = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            sat_add = s[ACC_WIDTH-1:0];
        end
    endfunction

endpackage

FILE: sv/gri_ctrl.sv
// Controller state machine for the gyro rate integrator
module gri_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  gri_pkg::t_sts     i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output gri_pkg::t_cmd     o_cmd
);

    gri_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gri_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gri_pkg::ST_IDLE: if (i_in_valid) n_state = gri_pkg::ST_ACCUM;
            gri_pkg::ST_ACCUM: begin
                if (!i_sts.round_end) begin
                    n_state = gri_pkg::ST_IDLE;
                end else if (!i_sts.phase) begin
                    n_state = i_sts.calib_done ? gri_pkg::ST_DIV : gri_pkg::ST_OUT;
                end else begin
                    n_state = gri_pkg::ST_DRIFT;
                end
            end
            gri_pkg::ST_DIV:   if (i_sts.div_last) n_state = gri_pkg::ST_OUT;
            gri_pkg::ST_DRIFT: if (i_sts.drift_last) n_state = gri_pkg::ST_OUT;
            gri_pkg::ST_OUT:   if (i_out_ready) n_state = gri_pkg::ST_IDLE;
            default: n_state = gri_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            gri_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            gri_pkg::ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                o_cmd.div_start = i_sts.round_end && !i_sts.phase && i_sts.calib_done;
                o_cmd.drift_start = i_sts.round_end && i_sts.phase;
            end
            gri_pkg::ST_DIV: begin
                o_cmd.div_step = !i_sts.div_last;
                o_cmd.div_done = i_sts.div_last;
            end
            gri_pkg::ST_DRIFT: begin
                o_cmd.drift_step = !i_sts.drift_last;
                o_cmd.drift_apply = i_sts.drift_last;
            end
            gri_pkg::ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

FILE: sv/gri_dp.sv
// Datapath: gain multiply, saturating accumulators, mean divider, drift check
module gri_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [gri_pkg::IN_WIDTH-1:0]         i_in_data,
    input  logic                                 i_in_last,
    input  logic                                 i_cfg_we,
    input  logic [2:0]                           i_cfg_addr,
    input  logic [39:0]                          i_cfg_data,
    input  gri_pkg::t_cmd                        i_cmd,
    output gri_pkg::t_sts                        o_sts,
    output logic [gri_pkg::OUT_TDATA-1:0]        o_out_data,
    output logic                                 o_out_phase
);

    localparam int AW = gri_pkg::ACC_WIDTH;
    localparam int CW = gri_pkg::CNT_WIDTH;
    localparam int PW = gri_pkg::PROD_WIDTH;

    logic [gri_pkg::GAIN_WIDTH-1:0] r_gain;
    logic [15:0]                    r_target;
    logic [CW-1:0]                  r_period [3];
    logic signed [gri_pkg::AMT_WIDTH-1:0] r_amount;

    logic                 r_phase;
    logic signed [AW-1:0] r_angle [3];
    logic signed [AW-1:0] r_calib [3];
    logic [CW-1:0]        r_ccount, r_icount, r_start, r_tick;
    logic [CW-1:0]        r_dcount [3];
    logic [7:0]           r_status, r_status_in;
    logic                 r_last;
    logic signed [PW-1:0] r_prod [3];

    // division: one restoring step per cycle, three axes in lockstep
    logic [AW-1:0]        r_quo [3];
    logic [CW:0]          r_rem [3];
    logic                 r_neg [3];
    logic [gri_pkg::DSTEP_WIDTH-1:0] r_dstep;

    // drift: elapsed / period via one restoring step per cycle
    logic [CW-1:0]        r_eq [3];
    logic [CW:0]          r_erem [3];
    logic [5:0]           r_estep;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 24'd164;
            r_target <= 16'd800;
            r_period[0] <= 32'd1000;
            r_period[1] <= 32'd1000;
            r_period[2] <= 32'd1000;
            r_amount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                gri_pkg::REG_RATE_GAIN:    r_gain <= i_cfg_data[23:0];
                gri_pkg::REG_CALIB_TARGET: r_target <= i_cfg_data[15:0];
                gri_pkg::REG_DRIFT_X:      r_period[0] <= i_cfg_data[31:0];
                gri_pkg::REG_DRIFT_Y:      r_period[1] <= i_cfg_data[31:0];
                gri_pkg::REG_DRIFT_Z:      r_period[2] <= i_cfg_data[31:0];
                gri_pkg::REG_DRIFT_AMT:    r_amount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0] w_elapsed;
    assign w_elapsed = r_tick - r_start;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= PW'($signed(i_in_data[16*i +: 16]) *
                                 $signed({1'b0, r_gain}));
            end
            r_status_in <= i_in_data[55:48];
            r_tick <= i_in_data[87:56];
            r_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_ccount <= '0;
            r_icount <= '0;
            r_start <= '0;
            r_status <= '0;
            r_dstep <= '0;
            r_estep <= '0;
            for (int i = 0; i < 3; i++) begin
                r_angle[i] <= '0;
                r_calib[i] <= '0;
                r_dcount[i] <= '0;
            end
        end else begin
            if (i_cmd.accum) begin
                if (!r_phase) begin
                    for (int i = 0; i < 3; i++)
                        r_calib[i] <= gri_pkg::sat_add(r_calib[i], AW'(r_prod[i]));
                    if (r_ccount != '1) r_ccount <= r_ccount + 1'b1;
                end else begin
                    if (r_icount == '0) r_start <= r_tick;
                    for (int i = 0; i < 3; i++)
                        r_angle[i] <= gri_pkg::sat_add(r_angle[i], AW'(r_prod[i]));
                    if (r_icount != '1) r_icount <= r_icount + 1'b1;
                end
                if (r_last) r_status <= r_status_in;
            end
            if (i_cmd.div_start) begin
                // count already includes this sample
                r_dstep <= '0;
                for (int i = 0; i < 3; i++) begin
                    logic signed [AW-1:0] s;
                    s = gri_pkg::sat_add(r_calib[i], AW'(r_prod[i]));
                    r_neg[i] <= s[AW-1];
                    r_quo[i] <= s[AW-1] ? AW'(-s) : s;
                    r_rem[i] <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_dstep <= r_dstep + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    logic [CW:0] t;
                    t = {r_rem[i][CW-1:0], r_quo[i][AW-1]};
                    if (t >= {1'b0, r_ccount}) begin
                        r_rem[i] <= t - {1'b0, r_ccount};
                        r_quo[i] <= {r_quo[i][AW-2:0], 1'b1};
                    end else begin
                        r_rem[i] <= t;
                        r_quo[i] <= {r_quo[i][AW-2:0], 1'b0};
                    end
                end
            end
            if (i_cmd.div_done) begin
                r_phase <= 1'b1;
                for (int i = 0; i < 3; i++)
                    r_calib[i] <= r_neg[i] ? AW'(-r_quo[i]) : r_quo[i];
            end
            if (i_cmd.drift_start) begin
                r_estep <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_eq[i] <= '0;
                    r_erem[i] <= '0;
                end
            end
            if (i_cmd.drift_step) begin
                r_estep <= r_estep + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    logic [CW:0] t;
                    t = {r_erem[i][CW-1:0], w_elapsed[CW-1-r_estep[4:0]]};
                    if (t >= {1'b0, r_period[i]}) begin
                        r_erem[i] <= t - {1'b0, r_period[i]};
                        r_eq[i] <= {r_eq[i][CW-2:0], 1'b1};
                    end else begin
                        r_erem[i] <= t;
                        r_eq[i] <= {r_eq[i][CW-2:0], 1'b0};
                    end
                end
            end
            if (i_cmd.drift_apply) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_period[i] != '0 && r_eq[i] > r_dcount[i]) begin
                        r_dcount[i] <= r_dcount[i] + 1'b1;
                        r_angle[i] <= gri_pkg::sat_add(r_angle[i],
                                                       AW'(r_amount));
                    end
                end
            end
        end
    end

    // both dividers step until the counter reaches the step count, then
    // finish with the full quotient in place
    logic w_div_last, w_drift_last;
    assign w_div_last = (r_dstep == gri_pkg::DSTEP_WIDTH'(gri_pkg::DIV_STEPS));
    assign w_drift_last = (r_estep == 6'(CW));

    assign o_sts.round_end  = r_last;
    assign o_sts.calib_done = ((r_ccount == '1) ? r_ccount : r_ccount + 1'b1)
                              >= {16'd0, r_target};
    assign o_sts.phase      = r_phase;
    assign o_sts.div_last   = w_div_last;
    assign o_sts.drift_last = w_drift_last;

    always_comb begin
        o_out_data = '0;
        for (int i = 0; i < 3; i++) begin
            o_out_data[AW*i +: AW] = r_angle[i];
            o_out_data[3*AW + 40*i +: 40] = r_phase ? r_calib[i][39:0] : 40'd0;
        end
        o_out_data[3*AW + 120 +: 8] = r_status;
        o_out_data[3*AW + 128 +: CW] = r_icount;
    end
    assign o_out_phase = r_phase;

endmodule

FILE: sv/gyro_rate_integrator.sv
// Top level of the gyro rate integrator
// Flow: each word is loaded and accumulated; a non-final sample gives no output;
//   a round end in calibration goes to output, at the calibration end after the
//   56-step mean divider, while integrating after the 32-step drift quotient.
// Throughput: one word at a time; next word accepted after any result is taken.
// Reset: synchronous active-low i_rst_n restores register defaults, clears
//   all accumulators and counters and returns to the calibrating phase.
module gyro_rate_integrator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x_raw, y_raw, z_raw, status_in, tick_now
    input  logic [gri_pkg::IN_WIDTH-1:0]      s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // angle_x/y/z, offset_x/y/z, status_out, samples_taken
    output logic [gri_pkg::OUT_TDATA-1:0]     m_axis_tdata,
    // phase
    output logic                              m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_addr,
    input  logic [39:0]                       i_cfg_data
);

    gri_pkg::t_cmd w_cmd;
    gri_pkg::t_sts w_sts;

    gri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    gri_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (m_axis_tdata),
        .o_out_phase (m_axis_tuser)
    );

endmodule

FILE: sv/gri_checker.sv
// Port-level checker for the gyro rate integrator, bound to the top level
module gri_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_phase_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser ##1 m_axis_tvalid |-> m_axis_tuser)
        else $error("phase fell back to calibrating");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");

endmodule

bind gyro_rate_integrator gri_checker u_gri_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/gyro_rate_integrator_tb.sv
// Self-checking testbench for the gyro rate integrator: calibration, integration and drift.
module gyro_rate_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ACC_HI = (longint'(1) <<< (gri_pkg::ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [15:0] x, y, z;
        logic [7:0]         status;
        logic [31:0]        tick;
        logic               last;
    } t_sample;

    typedef struct packed {
        logic        phase;
        logic [55:0] ang_x, ang_y, ang_z;
        logic [39:0] off_x, off_y, off_z;
        logic [7:0]  status;
        logic [31:0] count;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [gri_pkg::IN_WIDTH-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [gri_pkg::OUT_TDATA-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_addr = gri_pkg::REG_RATE_GAIN;
    logic [39:0] i_cfg_data = '0;

    gyro_rate_integrator DUT (.*);

    always #6 i_clk = ~i_clk;

    // shadow of the block's registers and state
    int unsigned gain_r, target_r;
    int unsigned period_r[3];
    longint amount_r;
    bit phase_q;
    longint angle_q[3], calib_q[3];
    int unsigned calib_cnt_q, integ_cnt_q, start_tick_q;
    int unsigned drift_cnt_q[3];
    logic [7:0] status_q;

    t_sample sample_fifo[$];
    t_report report_fifo[$];
    int mismatches = 0;
    bit gaps_on = 1'b0, stalls_on = 1'b0;
    int in_gap = 0, out_stall = 0;
    longint unsigned run_tick = 0;

    function automatic longint sat_acc(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_HI) return ACC_HI;
        if (s < ACC_LO) return ACC_LO;
        return s;
    endfunction

    function automatic bit integrate_sample(t_sample smp, output t_report rep);
        longint prod[3];
        int unsigned elapsed;
        prod[0] = longint'(smp.x) * longint'(gain_r);
        prod[1] = longint'(smp.y) * longint'(gain_r);
        prod[2] = longint'(smp.z) * longint'(gain_r);
        rep = '0;
        if (!phase_q) begin
            for (int i = 0; i < 3; i++) calib_q[i] = sat_acc(calib_q[i], prod[i]);
            if (calib_cnt_q != 32'hFFFF_FFFF) calib_cnt_q++;
        end else begin
            if (integ_cnt_q == 0) start_tick_q = smp.tick;
            for (int i = 0; i < 3; i++) angle_q[i] = sat_acc(angle_q[i], prod[i]);
            if (integ_cnt_q != 32'hFFFF_FFFF) integ_cnt_q++;
        end
        if (!smp.last) return 1'b0;
        status_q = smp.status;
        if (!phase_q) begin
            if (calib_cnt_q >= target_r) begin
                for (int i = 0; i < 3; i++)
                    calib_q[i] = calib_q[i] / longint'({32'd0, calib_cnt_q});
                phase_q = 1'b1;
            end
        end else begin
            elapsed = smp.tick - start_tick_q;
            for (int i = 0; i < 3; i++) begin
                if (period_r[i] != 0 && (elapsed / period_r[i]) > drift_cnt_q[i]) begin
                    drift_cnt_q[i]++;
                    angle_q[i] = sat_acc(angle_q[i], amount_r);
                end
            end
        end
        rep.phase = phase_q;
        rep.ang_x = angle_q[0][55:0];
        rep.ang_y = angle_q[1][55:0];
        rep.ang_z = angle_q[2][55:0];
        if (phase_q) begin
            rep.off_x = calib_q[0][39:0];
            rep.off_y = calib_q[1][39:0];
            rep.off_z = calib_q[2][39:0];
        end
        rep.status = status_q;
        rep.count = integ_cnt_q;
        return 1'b1;
    endfunction

    // sender: hold the word until taken, then pause for the chosen gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (sample_fifo.size() > 0) begin
                t_sample smp;
                smp = sample_fifo.pop_front();
                s_axis_tdata <= {smp.tick, smp.status, smp.z, smp.y, smp.x};
                s_axis_tlast <= smp.last;
                s_axis_tvalid <= 1'b1;
                if (gaps_on) begin
                    if ($urandom_range(0, 19) == 0) in_gap <= $urandom_range(20, 80);
                    else if ($urandom_range(0, 2) == 0) in_gap <= $urandom_range(1, 3);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // predict on every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_sample smp;
            t_report rep;
            smp.x = s_axis_tdata[15:0];
            smp.y = s_axis_tdata[31:16];
            smp.z = s_axis_tdata[47:32];
            smp.status = s_axis_tdata[55:48];
            smp.tick = s_axis_tdata[87:56];
            smp.last = s_axis_tlast;
            if (integrate_sample(smp, rep)) report_fifo.push_back(rep);
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    // receiver: random stalls, compare each word with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                m_axis_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 24) == 0) begin
                out_stall <= $urandom_range(10, 70);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !stalls_on || ($urandom_range(0, 3) != 0);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (report_fifo.size() == 0) begin
                    if (mismatches < 10) $display("%0t: unexpected output word", $realtime);
                    mismatches++;
                end else begin
                    t_report want;
                    want = report_fifo.pop_front();
                    check_field("phase", want.phase, m_axis_tuser);
                    check_field("angle_x", want.ang_x, m_axis_tdata[55:0]);
                    check_field("angle_y", want.ang_y, m_axis_tdata[111:56]);
                    check_field("angle_z", want.ang_z, m_axis_tdata[167:112]);
                    check_field("offset_x", want.off_x, m_axis_tdata[207:168]);
                    check_field("offset_y", want.off_y, m_axis_tdata[247:208]);
                    check_field("offset_z", want.off_z, m_axis_tdata[287:248]);
                    check_field("status_out", want.status, m_axis_tdata[295:288]);
                    check_field("samples_taken", want.count, m_axis_tdata[327:296]);
                end
            end
        end
    end

    task automatic add_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [7:0] st, logic [31:0] tk, logic last);
        t_sample smp;
        smp.x = x;
        smp.y = y;
        smp.z = z;
        smp.status = st;
        smp.tick = tk;
        smp.last = last;
        sample_fifo.push_back(smp);
    endtask

    function automatic logic [15:0] rand_rate();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            gri_pkg::REG_RATE_GAIN:    gain_r = 32'(val[23:0]);
            gri_pkg::REG_CALIB_TARGET: target_r = 32'(val[15:0]);
            gri_pkg::REG_DRIFT_X:      period_r[0] = val[31:0];
            gri_pkg::REG_DRIFT_Y:      period_r[1] = val[31:0];
            gri_pkg::REG_DRIFT_Z:      period_r[2] = val[31:0];
            gri_pkg::REG_DRIFT_AMT:    amount_r = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for all words out, then let a late result land
    task automatic drain();
        do @(negedge i_clk);
        while (sample_fifo.size() != 0 || s_axis_tvalid || report_fifo.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_period(int k);
        case ((k + $urandom_range(0, 3)) % 5)
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    initial begin
        gain_r = 164;
        target_r = 800;
        period_r = '{1000, 1000, 1000};
        amount_r = 0;
        phase_q = 1'b0;
        angle_q = '{0, 0, 0};
        calib_q = '{0, 0, 0};
        calib_cnt_q = 0;
        integ_cnt_q = 0;
        start_tick_q = 0;
        drift_cnt_q = '{0, 0, 0};
        status_q = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        write_reg(gri_pkg::REG_RATE_GAIN, 40'hFF_FFFF);
        write_reg(gri_pkg::REG_CALIB_TARGET, 40'd3);
        write_reg(gri_pkg::REG_DRIFT_X, 40'd1);
        write_reg(gri_pkg::REG_DRIFT_Y, 40'd0);
        write_reg(gri_pkg::REG_DRIFT_Z, 40'hFFFF_FFFF);
        write_reg(gri_pkg::REG_DRIFT_AMT, 40'h80_0000_0000);
        end_writes();

        // calibrating: round end short of the target, then the one that ends it
        add_sample(16'h7FFF, 16'h8000, 16'h0000, 8'hA5, 32'd10, 1'b0);
        add_sample(16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 32'd11, 1'b1);
        add_sample(16'h0001, 16'h8000, 16'h8000, 8'h00, 32'd12, 1'b1);
        // integrating: first sample sets the start tick
        add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h5A, 32'hFFFF_FFF0, 1'b0);
        add_sample(16'h8000, 16'h8000, 16'h8000, 8'h01, 32'hFFFF_FFF0, 1'b1);
        add_sample(16'h1234, 16'hEDCB, 16'h0000, 8'h80, 32'hFFFF_FFF8, 1'b1);
        // elapsed time wraps past zero
        add_sample(16'hFFFF, 16'h0001, 16'h7FFF, 8'h7F, 32'h0000_0004, 1'b1);
        add_sample(16'h0000, 16'h0000, 16'h0000, 8'hFF, 32'h0000_0004, 1'b1);
        add_sample(16'h4000, 16'hC000, 16'h2000, 8'h3C, 32'h0001_0000, 1'b0);
        add_sample(16'h8000, 16'h7FFF, 16'h8000, 8'hC3, 32'hFFFF_FFEF, 1'b1);
        drain();

        for (int k = 0; k < 8; k++) begin
            case (k % 4)
                0: write_reg(gri_pkg::REG_RATE_GAIN, 40'd0);
                1: write_reg(gri_pkg::REG_RATE_GAIN, 40'hFF_FFFF);
                default: write_reg(gri_pkg::REG_RATE_GAIN,
                                   40'($urandom_range(1, 24'hFF_FFFF)));
            endcase
            write_reg(gri_pkg::REG_CALIB_TARGET,
                      (k == 1) ? 40'hFFFF : 40'($urandom_range(0, 65535)));
            write_reg(gri_pkg::REG_DRIFT_X, 40'(rand_period(k)));
            write_reg(gri_pkg::REG_DRIFT_Y, 40'(rand_period(k + 1)));
            write_reg(gri_pkg::REG_DRIFT_Z, 40'(rand_period(k + 2)));
            case (k % 4)
                0: write_reg(gri_pkg::REG_DRIFT_AMT, 40'h7F_FFFF_FFFF);
                1: write_reg(gri_pkg::REG_DRIFT_AMT, 40'h80_0000_0000);
                2: write_reg(gri_pkg::REG_DRIFT_AMT, 40'd0);
                default: write_reg(gri_pkg::REG_DRIFT_AMT, {$urandom(), 8'($urandom())});
            endcase
            end_writes();
            gaps_on = (k % 3) != 0;
            stalls_on = (k % 3) != 1;
            for (int n = 0; n < 105; n++) begin
                if ($urandom_range(0, 19) == 0) run_tick = $urandom();
                else run_tick += $urandom_range(0, 40);
                add_sample(rand_rate(), rand_rate(), rand_rate(), 8'($urandom()),
                           run_tick[31:0], $urandom_range(0, 2) == 0);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
